/* rtl/core/cpsp_pkg.sv */
// Package for the cascaded position/speed PID controller.
// Holds the shared widths, fixed-point constants, register indexes and the
// control struct that steps the shared multiply-accumulate unit.
package cpsp_pkg;

   // Fixed-point and storage widths.
   localparam int GAIN_FRAC_BITS = 12;
   localparam int SUM_WIDTH      = 48;
   localparam int GAIN_W         = 16;
   localparam int LIMIT_W        = 7;
   localparam int DELTA_W        = 16;
   localparam int POS_W          = 32;
   localparam int OERR_W         = POS_W + 1;
   localparam int IERR_W         = 32;
   localparam int DIFF_W         = OERR_W + 1;
   localparam int OPND_W         = (SUM_WIDTH > DIFF_W) ? SUM_WIDTH : DIFF_W;
   localparam int PROD_W         = OPND_W + GAIN_W + 1;
   localparam int ACC_W          = 64;
   localparam int PROD_BOUND_EXP = 61;

   // Register file.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_OUTER_KP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUTER_KI = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUTER_KD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_KP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_KI = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_KD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT    = 3'd6;

   localparam logic [GAIN_W-1:0]  RST_OUTER_KP = 16'd1638;
   localparam logic [GAIN_W-1:0]  RST_OUTER_KI = 16'd0;
   localparam logic [GAIN_W-1:0]  RST_OUTER_KD = 16'd819;
   localparam logic [GAIN_W-1:0]  RST_INNER_KP = 16'd4096;
   localparam logic [GAIN_W-1:0]  RST_INNER_KI = 16'd2458;
   localparam logic [GAIN_W-1:0]  RST_INNER_KD = 16'd0;
   localparam logic [LIMIT_W-1:0] RST_LIMIT    = 7'd100;

   // Control of the shared multiply-accumulate unit.
   typedef struct packed {
      logic clear;   // zero the accumulator
      logic load;    // capture a new product
      logic accum;   // add the saturated product to the accumulator
   } mac_ctrl_type;

endpackage

/* rtl/core/cascaded_position_speed_pid.sv */
// Cascaded position/speed PID controller: one transaction is one control tick.
// A result is registered in DONE once the response register is free to take it.
// A new request is taken only in IDLE, after the last result is offered, since the
// single shared multiplier forms the six gain products of both loops in turn.
// Reset (synchronous, active high) restores the default gains and limit and
// zeroes the position count, both integrals and both previous errors.
module cascaded_position_speed_pid (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [cpsp_pkg::DELTA_W-1:0]    req_count_delta,
   input  logic signed [cpsp_pkg::POS_W-1:0]      req_target_position,
   input  logic                                   req_hold,
   // Response channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic        [cpsp_pkg::LIMIT_W-1:0]    rsp_drive_magnitude,
   output logic                                   rsp_drive_reverse,
   output logic signed [cpsp_pkg::POS_W-1:0]      rsp_position_count,
   // Register port.
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic        [cpsp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic        [cpsp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic        [cpsp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                   csr_pready
);
   import cpsp_pkg::*;

   // Sequencer states. Each loop runs SUM, MP, MI, MD and ACC in turn; the
   // outer loop then passes through LIMIT to form the inner error, and the
   // inner loop ends in DONE, where the drive is worked out.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ERR   = 4'd1;
   localparam logic [3:0] ST_SUM   = 4'd2;
   localparam logic [3:0] ST_MP    = 4'd3;
   localparam logic [3:0] ST_MI    = 4'd4;
   localparam logic [3:0] ST_MD    = 4'd5;
   localparam logic [3:0] ST_ACC   = 4'd6;
   localparam logic [3:0] ST_LIMIT = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   // Configuration registers.
   logic [GAIN_W-1:0]  okp_ff, oki_ff, okd_ff, ikp_ff, iki_ff, ikd_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // Sequencer and controller state.
   logic [3:0]                  state_ff, state_in;
   logic                        inner_ff, inner_in;
   logic signed [POS_W-1:0]     pos_ff, pos_in;
   logic signed [POS_W-1:0]     tgt_ff, tgt_in;
   logic signed [DELTA_W-1:0]   delta_ff, delta_in;
   logic signed [OERR_W-1:0]    err_ff, err_in;
   logic signed [DIFF_W-1:0]    diff_ff, diff_in;
   logic signed [OERR_W-1:0]    olast_ff, olast_in;
   logic signed [IERR_W-1:0]    ilast_ff, ilast_in;
   logic signed [SUM_WIDTH-1:0] osum_ff, osum_in;
   logic signed [SUM_WIDTH-1:0] isum_ff, isum_in;

   // Response register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0]          rsp_mag_ff, rsp_mag_in;
   logic                        rsp_rev_ff, rsp_rev_in;
   logic signed [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;

   // Datapath.
   mac_ctrl_type                mac_ctrl;
   logic signed [OPND_W-1:0]    mac_opnd;
   logic [GAIN_W-1:0]           mac_gain;
   logic signed [ACC_W-1:0]     mac_acc;

   logic                        req_accept;
   logic                        rsp_free;
   logic                        csr_write;
   logic [CSR_IDX_W-1:0]        csr_idx;

   logic signed [SUM_WIDTH-1:0] cur_sum;
   logic [GAIN_W-1:0]           cur_ki;
   logic signed [SUM_WIDTH:0]   sum_wide;
   logic signed [SUM_WIDTH-1:0] sum_sat;
   logic signed [SUM_WIDTH-1:0] sum_next;
   logic signed [OERR_W-1:0]    last_sel;

   logic signed [ACC_W-1:0]     lim_q;
   logic signed [ACC_W-1:0]     outer_out;
   logic signed [ACC_W-1:0]     inner_err;

   logic                        drv_neg;
   logic [ACC_W-1:0]            drv_abs;
   logic [ACC_W-1:0]            drv_int;
   logic [LIMIT_W-1:0]          drv_mag;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   // The response register can take a new result when empty or when its
   // current transaction completes in this cycle.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      case (csr_idx)
         REG_OUTER_KP: csr_prdata = CSR_DATA_W'(okp_ff);
         REG_OUTER_KI: csr_prdata = CSR_DATA_W'(oki_ff);
         REG_OUTER_KD: csr_prdata = CSR_DATA_W'(okd_ff);
         REG_INNER_KP: csr_prdata = CSR_DATA_W'(ikp_ff);
         REG_INNER_KI: csr_prdata = CSR_DATA_W'(iki_ff);
         REG_INNER_KD: csr_prdata = CSR_DATA_W'(ikd_ff);
         REG_LIMIT:    csr_prdata = CSR_DATA_W'(limit_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // Integral update for the loop being worked on: a Ki of zero clears the
   // sum, otherwise the error is added with saturation at the sum width.
   assign cur_sum  = inner_ff ? isum_ff : osum_ff;
   assign cur_ki   = inner_ff ? iki_ff : oki_ff;
   assign sum_wide = (SUM_WIDTH+1)'(cur_sum) + (SUM_WIDTH+1)'(err_ff);

   always_comb begin
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_WIDTH-1:0];
      end
      sum_next = (cur_ki == '0) ? '0 : sum_sat;
   end

   assign last_sel = inner_ff ? OERR_W'(ilast_ff) : olast_ff;

   // Outer output clamped in Q.F, then the inner error is the speed target
   // minus the measured delta, both with GAIN_FRAC_BITS fraction bits.
   assign lim_q = ACC_W'({limit_ff, {GAIN_FRAC_BITS{1'b0}}});

   always_comb begin
      if (mac_acc > lim_q) begin
         outer_out = lim_q;
      end else if (mac_acc < -lim_q) begin
         outer_out = -lim_q;
      end else begin
         outer_out = mac_acc;
      end
      inner_err = outer_out - (ACC_W'(delta_ff) <<< GAIN_FRAC_BITS);
   end

   // Inner output truncated toward zero, clamped and split into magnitude
   // and direction; a zero drive always reads as forward.
   always_comb begin
      drv_neg = mac_acc[ACC_W-1];
      drv_abs = drv_neg ? ACC_W'(-mac_acc) : ACC_W'(mac_acc);
      drv_int = drv_abs >> (2 * GAIN_FRAC_BITS);
      if (drv_int > ACC_W'(limit_ff)) begin
         drv_mag = limit_ff;
      end else begin
         drv_mag = drv_int[LIMIT_W-1:0];
      end
   end

   // Operand and gain steering for the shared unit.
   always_comb begin
      mac_ctrl = '0;
      mac_opnd = OPND_W'(err_ff);
      mac_gain = inner_ff ? ikp_ff : okp_ff;
      case (state_ff)
         ST_MP: begin
            mac_ctrl.clear = 1'b1;
            mac_ctrl.load  = 1'b1;
         end
         ST_MI: begin
            mac_ctrl.load  = 1'b1;
            mac_ctrl.accum = 1'b1;
            mac_opnd       = OPND_W'(cur_sum);
            mac_gain       = cur_ki;
         end
         ST_MD: begin
            mac_ctrl.load  = 1'b1;
            mac_ctrl.accum = 1'b1;
            mac_opnd       = OPND_W'(diff_ff);
            mac_gain       = inner_ff ? ikd_ff : okd_ff;
         end
         ST_ACC: begin
            mac_ctrl.accum = 1'b1;
         end
         default: begin
            mac_ctrl = '0;
         end
      endcase
   end

   cpsp_mac u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .operand (mac_opnd),
      .gain    (mac_gain),
      .acc     (mac_acc)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      inner_in     = inner_ff;
      pos_in       = pos_ff;
      tgt_in       = tgt_ff;
      delta_in     = delta_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      olast_in     = olast_ff;
      ilast_in     = ilast_ff;
      osum_in      = osum_ff;
      isum_in      = isum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mag_in   = rsp_mag_ff;
      rsp_rev_in   = rsp_rev_ff;
      rsp_pos_in   = rsp_pos_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // Hold takes the position before this tick's delta as the
               // target and clears both integrals before they are updated.
               pos_in   = pos_ff + POS_W'(req_count_delta);
               tgt_in   = req_hold ? pos_ff : req_target_position;
               delta_in = req_count_delta;
               inner_in = 1'b0;
               if (req_hold) begin
                  osum_in = '0;
                  isum_in = '0;
               end
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            err_in   = OERR_W'(tgt_ff) - OERR_W'(pos_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            diff_in = DIFF_W'(err_ff) - DIFF_W'(last_sel);
            if (inner_ff) begin
               isum_in  = sum_next;
               ilast_in = err_ff[IERR_W-1:0];
            end else begin
               osum_in  = sum_next;
               olast_in = err_ff;
            end
            state_in = ST_MP;
         end
         ST_MP: begin
            state_in = ST_MI;
         end
         ST_MI: begin
            state_in = ST_MD;
         end
         ST_MD: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = inner_ff ? ST_DONE : ST_LIMIT;
         end
         ST_LIMIT: begin
            err_in   = inner_err[OERR_W-1:0];
            inner_in = 1'b1;
            state_in = ST_SUM;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_mag_in   = drv_mag;
               rsp_rev_in   = drv_neg && (drv_mag != '0);
               rsp_pos_in   = pos_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state, controller state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inner_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         olast_ff     <= '0;
         ilast_ff     <= '0;
         osum_ff      <= '0;
         isum_ff      <= '0;
         okp_ff       <= RST_OUTER_KP;
         oki_ff       <= RST_OUTER_KI;
         okd_ff       <= RST_OUTER_KD;
         ikp_ff       <= RST_INNER_KP;
         iki_ff       <= RST_INNER_KI;
         ikd_ff       <= RST_INNER_KD;
         limit_ff     <= RST_LIMIT;
      end else begin
         state_ff     <= state_in;
         inner_ff     <= inner_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         olast_ff     <= olast_in;
         ilast_ff     <= ilast_in;
         osum_ff      <= osum_in;
         isum_ff      <= isum_in;
         if (csr_write) begin
            case (csr_idx)
               REG_OUTER_KP: okp_ff   <= csr_pwdata[GAIN_W-1:0];
               REG_OUTER_KI: oki_ff   <= csr_pwdata[GAIN_W-1:0];
               REG_OUTER_KD: okd_ff   <= csr_pwdata[GAIN_W-1:0];
               REG_INNER_KP: ikp_ff   <= csr_pwdata[GAIN_W-1:0];
               REG_INNER_KI: iki_ff   <= csr_pwdata[GAIN_W-1:0];
               REG_INNER_KD: ikd_ff   <= csr_pwdata[GAIN_W-1:0];
               REG_LIMIT:    limit_ff <= csr_pwdata[LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Working registers and response payload need no reset.
   always_ff @(posedge clock) begin
      tgt_ff     <= tgt_in;
      delta_ff   <= delta_in;
      err_ff     <= err_in;
      diff_ff    <= diff_in;
      rsp_mag_ff <= rsp_mag_in;
      rsp_rev_ff <= rsp_rev_in;
      rsp_pos_ff <= rsp_pos_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_magnitude = rsp_mag_ff;
   assign rsp_drive_reverse   = rsp_rev_ff;
   assign rsp_position_count  = rsp_pos_ff;

endmodule

/* rtl/core/cpsp_mac.sv */
// Shared multiply-accumulate unit of the cascaded PID controller.
// One signed-by-unsigned product per cycle while load is set, saturated to +/-2^61 and summed.
// Depends on cpsp_pkg.
module cpsp_mac (
   input  logic                                clock,
   input  cpsp_pkg::mac_ctrl_type              ctrl,
   input  logic signed [cpsp_pkg::OPND_W-1:0]  operand,
   input  logic        [cpsp_pkg::GAIN_W-1:0]  gain,
   output logic signed [cpsp_pkg::ACC_W-1:0]   acc
);
   import cpsp_pkg::*;

   localparam logic signed [PROD_W-1:0] BOUND_POS = PROD_W'(1) << PROD_BOUND_EXP;
   localparam logic signed [PROD_W-1:0] BOUND_NEG = -BOUND_POS;

   logic signed [PROD_W-1:0] mul_res;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_sat;
   logic signed [ACC_W-1:0]  acc_ff;

   assign mul_res = operand * $signed({1'b0, gain});

   always_comb begin
      if (prod_ff > BOUND_POS) begin
         prod_sat = BOUND_POS;
      end else if (prod_ff < BOUND_NEG) begin
         prod_sat = BOUND_NEG;
      end else begin
         prod_sat = prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= mul_res;
      end
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (ctrl.accum) begin
         acc_ff <= acc_ff + prod_sat[ACC_W-1:0];
      end
   end

   assign acc = acc_ff;

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the cascaded position/speed PID controller.
// Needs cpsp_pkg, cascaded_position_speed_pid and cpsp_mac from the RTL; nothing else.
// A control-law predictor computes every drive result, and a monitor checks each one.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cpsp_pkg::*;

   // One control tick as offered on the request channel.
   typedef struct {
      logic signed [DELTA_W-1:0] delta;
      logic signed [POS_W-1:0]   target;
      logic                      hold;
   } control_tick_type;

   // One drive command as returned on the response channel.
   typedef struct {
      logic [LIMIT_W-1:0]      magnitude;
      logic                    reverse;
      logic signed [POS_W-1:0] position;
   } drive_result_type;

   localparam int OUTER_LOOP = 0;
   localparam int INNER_LOOP = 1;
   localparam longint PRODUCT_CLIP = longint'(1) << PROD_BOUND_EXP;
   localparam longint ERR_SUM_MAX  = (longint'(1) << (SUM_WIDTH - 1)) - 1;
   localparam longint ERR_SUM_MIN  = -ERR_SUM_MAX - 1;

   // Clock and reset. Every input of the block starts at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [DELTA_W-1:0] req_count_delta = '0;
   logic signed [POS_W-1:0]   req_target_position = '0;
   logic                      req_hold = 1'b0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [LIMIT_W-1:0]        rsp_drive_magnitude;
   logic                      rsp_drive_reverse;
   logic signed [POS_W-1:0]   rsp_position_count;

   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   cascaded_position_speed_pid dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_count_delta     (req_count_delta),
      .req_target_position (req_target_position),
      .req_hold            (req_hold),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_drive_magnitude (rsp_drive_magnitude),
      .rsp_drive_reverse   (rsp_drive_reverse),
      .rsp_position_count  (rsp_position_count),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // Ticks waiting to be offered, and drive results waiting to be seen.
   control_tick_type tick_pending_q[$];
   drive_result_type drive_expected_q[$];

   // Idling percentages of each side, and the long receiver hold-off.
   int send_idle_pct = 36;
   int recv_idle_pct = 36;
   int holdoff_left  = 0;
   int mismatch_count = 0;

   // Position that the stimulus generator believes the block holds once every
   // queued tick has gone through; used to aim targets near the wheel.
   logic signed [POS_W-1:0] plan_position = '0;

   logic signed [DELTA_W-1:0] delta_corners [5] = '{16'sh8000, 16'sh7fff, 16'sh0000,
                                                    16'shffff, 16'sh0001};
   logic signed [POS_W-1:0]   target_corners [5] = '{32'sh8000_0000, 32'sh7fff_ffff,
                                                     32'sh0000_0000, 32'shffff_ffff,
                                                     32'sh0000_0001};

   // ------------------------------------------------------------------------
   // Control-law predictor. It keeps its own copy of the registers and of the
   // loop state, indexed by loop (outer position loop, inner speed loop).
   // ------------------------------------------------------------------------
   logic [GAIN_W-1:0]  prop_gain  [2] = '{RST_OUTER_KP, RST_INNER_KP};
   logic [GAIN_W-1:0]  integ_gain [2] = '{RST_OUTER_KI, RST_INNER_KI};
   logic [GAIN_W-1:0]  deriv_gain [2] = '{RST_OUTER_KD, RST_INNER_KD};
   logic [LIMIT_W-1:0] drive_limit = RST_LIMIT;

   logic signed [POS_W-1:0] wheel_position = '0;
   longint last_error [2] = '{0, 0};
   longint error_sum  [2] = '{0, 0};

   // Gain product, clipped at a bound far beyond anything the clamps let through.
   function automatic longint clipped_product(input longint a, input longint g);
      longint mag;
      if (g == 0 || a == 0)
         return 0;
      mag = (a < 0) ? -a : a;
      if (mag > PRODUCT_CLIP / g)
         return (a < 0) ? -PRODUCT_CLIP : PRODUCT_CLIP;
      return (a < 0) ? -(mag * g) : mag * g;
   endfunction

   // One PID update: the integral is cleared while Ki is zero, otherwise it
   // accumulates with saturation at the signed sum width.
   function automatic longint step_loop(input int loop, input longint err);
      longint sum_out;
      if (integ_gain[loop] == 0)
         error_sum[loop] = 0;
      else if (err > 0 && error_sum[loop] > ERR_SUM_MAX - err)
         error_sum[loop] = ERR_SUM_MAX;
      else if (err < 0 && error_sum[loop] < ERR_SUM_MIN - err)
         error_sum[loop] = ERR_SUM_MIN;
      else
         error_sum[loop] = error_sum[loop] + err;
      sum_out = clipped_product(err, longint'(prop_gain[loop]))
              + clipped_product(error_sum[loop], longint'(integ_gain[loop]))
              + clipped_product(err - last_error[loop], longint'(deriv_gain[loop]));
      last_error[loop] = err;
      return sum_out;
   endfunction

   function automatic drive_result_type predict_drive(input control_tick_type tick);
      drive_result_type drive;
      longint         aim;
      longint         speed_target;
      longint         speed_error;
      longint         command;
      longint         clamp;
      longint         mag;
      logic           negative;
      aim = longint'(tick.target);
      // Hold pins the target to the position before this tick's movement.
      if (tick.hold) begin
         aim = longint'(wheel_position);
         error_sum[OUTER_LOOP] = 0;
         error_sum[INNER_LOOP] = 0;
      end
      wheel_position = wheel_position + POS_W'(tick.delta);
      clamp = longint'(drive_limit) << GAIN_FRAC_BITS;
      speed_target = step_loop(OUTER_LOOP, aim - longint'(wheel_position));
      if (speed_target > clamp)
         speed_target = clamp;
      if (speed_target < -clamp)
         speed_target = -clamp;
      speed_error = speed_target - longint'(tick.delta) * (longint'(1) << GAIN_FRAC_BITS);
      command = step_loop(INNER_LOOP, speed_error);
      negative = (command < 0);
      mag = negative ? -command : command;
      mag = mag >> (2 * GAIN_FRAC_BITS);
      if (mag > longint'(drive_limit))
         mag = longint'(drive_limit);
      if (mag == 0)
         negative = 1'b0;
      drive.magnitude = LIMIT_W'(mag);
      drive.reverse   = negative;
      drive.position  = wheel_position;
      return drive;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver. A tick is predicted at the edge that accepts it, and the
   // payload only moves once the previous transaction has gone or none is up.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_ticks
      control_tick_type next_tick;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            next_tick.delta  = req_count_delta;
            next_tick.target = req_target_position;
            next_tick.hold   = req_hold;
            drive_expected_q.push_back(predict_drive(next_tick));
         end
         if (!req_valid || !req_stall) begin
            if (tick_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_tick = tick_pending_q.pop_front();
               req_valid           <= 1'b1;
               req_count_delta     <= next_tick.delta;
               req_target_position <= next_tick.target;
               req_hold            <= next_tick.hold;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor. Each accepted drive result is compared field by field
   // with the oldest prediction; the receiver stalls at random and, when
   // asked, holds off for a long run of cycles counted here.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_drives
      drive_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (drive_expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: drive result with no tick outstanding: mag %0d rev %0b pos %0d",
                           $realtime, rsp_drive_magnitude, rsp_drive_reverse,
                           rsp_position_count);
            end else begin
               want = drive_expected_q.pop_front();
               if (want.magnitude !== rsp_drive_magnitude || want.reverse !== rsp_drive_reverse
                   || want.position !== rsp_position_count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: expected mag/rev/pos %0d/%0b/%0d, got %0d/%0b/%0d",
                              $realtime, want.magnitude, want.reverse, want.position,
                              rsp_drive_magnitude, rsp_drive_reverse, rsp_position_count);
               end
            end
         end
         if (holdoff_left > 0)
            holdoff_left--;
         rsp_stall <= (holdoff_left > 0) || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Register access and stimulus helpers.
   // ------------------------------------------------------------------------

   // Two-phase register write; the predictor's copy follows once the access
   // phase has completed.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_OUTER_KP: prop_gain[OUTER_LOOP]  = value[GAIN_W-1:0];
         REG_OUTER_KI: integ_gain[OUTER_LOOP] = value[GAIN_W-1:0];
         REG_OUTER_KD: deriv_gain[OUTER_LOOP] = value[GAIN_W-1:0];
         REG_INNER_KP: prop_gain[INNER_LOOP]  = value[GAIN_W-1:0];
         REG_INNER_KI: integ_gain[INNER_LOOP] = value[GAIN_W-1:0];
         REG_INNER_KD: deriv_gain[INNER_LOOP] = value[GAIN_W-1:0];
         REG_LIMIT:    drive_limit            = value[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [GAIN_W-1:0] outer_kp, outer_ki, outer_kd,
                                 input logic [GAIN_W-1:0] inner_kp, inner_ki, inner_kd,
                                 input logic [LIMIT_W-1:0] limit);
      write_register(REG_OUTER_KP, CSR_DATA_W'(outer_kp));
      write_register(REG_OUTER_KI, CSR_DATA_W'(outer_ki));
      write_register(REG_OUTER_KD, CSR_DATA_W'(outer_kd));
      write_register(REG_INNER_KP, CSR_DATA_W'(inner_kp));
      write_register(REG_INNER_KI, CSR_DATA_W'(inner_ki));
      write_register(REG_INNER_KD, CSR_DATA_W'(inner_kd));
      write_register(REG_LIMIT,    CSR_DATA_W'(limit));
   endtask

   // Waits until every tick has been accepted and every drive result seen,
   // then lets the block's latency run out before anything else happens.
   task automatic wait_until_drained();
      while (tick_pending_q.size() != 0 || req_valid || drive_expected_q.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic queue_tick(input logic signed [DELTA_W-1:0] delta,
                             input logic signed [POS_W-1:0] target, input logic hold);
      control_tick_type tick;
      tick.delta  = delta;
      tick.target = target;
      tick.hold   = hold;
      tick_pending_q.push_back(tick);
      plan_position = plan_position + POS_W'(delta);
   endtask

   // Field extremes, hold with and without movement, and a wheel at rest.
   task automatic queue_directed_ticks();
      queue_tick(16'sd0, 32'sd0, 1'b0);
      queue_tick(16'sh7fff, 32'sh7fff_ffff, 1'b0);
      queue_tick(16'sh8000, 32'sh8000_0000, 1'b0);
      queue_tick(16'sd0, 32'sd0, 1'b1);
      queue_tick(16'sh7fff, 32'sd123456, 1'b1);
      queue_tick(16'sh8000, -32'sd1, 1'b1);
      queue_tick(16'sd1, 32'sd1, 1'b0);
      queue_tick(-16'sd1, 32'sh7fff_ffff, 1'b0);
      queue_tick(16'sd0, 32'sh8000_0000, 1'b0);
      queue_tick(16'sd100, 32'sd500, 1'b0);
      queue_tick(-16'sd100, -32'sd500, 1'b0);
      queue_tick(16'sd0, 32'sd0, 1'b0);
   endtask

   // Mostly a wheel tracking a nearby target with modest movement, so that
   // the loops work away from their clamps; the rest is raw noise and corners.
   task automatic queue_random_ticks(input int count);
      logic signed [DELTA_W-1:0] delta;
      logic signed [POS_W-1:0]   target;
      logic                      hold;
      int                        pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            delta  = DELTA_W'(int'($urandom_range(400)) - 200);
            target = plan_position + POS_W'(int'($urandom_range(8000)) - 4000);
            hold   = ($urandom_range(9) == 0);
         end else if (pick < 85) begin
            delta  = DELTA_W'($urandom);
            target = POS_W'($urandom);
            hold   = 1'($urandom_range(1));
         end else begin
            delta  = delta_corners[$urandom_range(4)];
            target = ($urandom_range(5) == 5) ? plan_position
                                              : target_corners[$urandom_range(4)];
            hold   = 1'($urandom_range(1));
         end
         queue_tick(delta, target, hold);
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence. Reset is held at the start, after which the run steps
   // through several register settings, draining the block before each write.
   // ------------------------------------------------------------------------
   initial begin : run_sequence
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset gains and limit first, so that the defaults are checked too.
      queue_directed_ticks();
      queue_random_ticks(150);
      wait_until_drained();

      // Every gain at its top value and the widest limit.
      apply_settings('1, '1, '1, '1, '1, '1, 7'd127);
      queue_directed_ticks();
      queue_random_ticks(150);
      wait_until_drained();

      // All gains zero and a limit of 1: the drive must sit at zero,
      // forward, and both integrals are cleared.
      apply_settings('0, '0, '0, '0, '0, '0, 7'd1);
      queue_random_ticks(100);
      wait_until_drained();

      // A long stretch with neither side idling, on moderate gains.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(GAIN_W'($urandom_range(8192)), GAIN_W'($urandom_range(8192)),
                     GAIN_W'($urandom_range(8192)), GAIN_W'($urandom_range(8192)),
                     GAIN_W'($urandom_range(8192)), GAIN_W'($urandom_range(8192)),
                     LIMIT_W'($urandom_range(1, 127)));
      queue_random_ticks(350);
      wait_until_drained();

      // The receiver holds off for a long time while the sender keeps
      // offering, so the block backs up and stalls its request side.
      send_idle_pct = 0;
      recv_idle_pct = 36;
      apply_settings(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                     GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom), 7'd1);
      queue_random_ticks(300);
      @(negedge clock);
      holdoff_left = 400;
      wait_until_drained();

      send_idle_pct = 36;
      apply_settings(GAIN_W'($urandom), 16'd0, GAIN_W'($urandom),
                     GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                     LIMIT_W'($urandom_range(1, 127)));
      queue_random_ticks(350);
      wait_until_drained();

      // Back to the reset values, with integrals and errors carried over.
      apply_settings(RST_OUTER_KP, RST_OUTER_KI, RST_OUTER_KD,
                     RST_INNER_KP, RST_INNER_KI, RST_INNER_KD, RST_LIMIT);
      queue_random_ticks(300);
      wait_until_drained();

      if (mismatch_count == 0 && drive_expected_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin : watchdog
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
